[rtl/md5_pkg.sv]
// MD5 digest unit: shared types, constants and round functions.
package md5_pkg;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned BLK_WORDS   = 16;
   localparam int unsigned WIDX_W      = 4;
   localparam int unsigned ROUND_W     = 6;
   localparam int unsigned LEN_W       = 64;

   localparam logic [31:0] IV_A        = 32'h67452301;
   localparam logic [31:0] IV_B        = 32'hefcdab89;
   localparam logic [31:0] IV_C        = 32'h98badcfe;
   localparam logic [31:0] IV_D        = 32'h10325476;
   localparam logic [31:0] PAD_WORD    = 32'h00000080;

   localparam logic [3:0]  LAST_WIDX   = 4'd15;
   localparam logic [4:0]  LEN_FIT_MAX = 5'd13;
   localparam logic [4:0]  LEN_LO_POS  = 5'd14;
   localparam logic [4:0]  LEN_HI_POS  = 5'd15;
   localparam logic [2:0]  FULL_BYTES  = 3'd4;
   localparam logic [63:0] WORD_BITS   = 64'd32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_COMPRESS,
      ST_OUTPUT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      CORE_IDLE,
      CORE_ROUND,
      CORE_ADD
   } core_state_type;

   typedef struct packed {
      logic start;
      logic init;
   } core_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } core_stat_type;

   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
      logic [5:0] rs;
      rs = 6'd32 - {1'b0, s};
      return (v << s) | (v >> rs);
   endfunction

   function automatic logic [4:0] rot_amount(input logic [5:0] r);
      logic [4:0] s;
      case ({r[5:4], r[1:0]})
         4'b0000: s = 5'd7;
         4'b0001: s = 5'd12;
         4'b0010: s = 5'd17;
         4'b0011: s = 5'd22;
         4'b0100: s = 5'd5;
         4'b0101: s = 5'd9;
         4'b0110: s = 5'd14;
         4'b0111: s = 5'd20;
         4'b1000: s = 5'd4;
         4'b1001: s = 5'd11;
         4'b1010: s = 5'd16;
         4'b1011: s = 5'd23;
         4'b1100: s = 5'd6;
         4'b1101: s = 5'd10;
         4'b1110: s = 5'd15;
         default: s = 5'd21;
      endcase
      return s;
   endfunction

   function automatic logic [3:0] msg_index(input logic [5:0] r);
      logic [3:0] r4;
      logic [3:0] g;
      r4 = r[3:0];
      case (r[5:4])
         2'd0:    g = r4;
         2'd1:    g = (r4 << 2) + r4 + 4'd1;
         2'd2:    g = (r4 << 1) + r4 + 4'd5;
         default: g = (r4 << 3) - r4;
      endcase
      return g;
   endfunction

   function automatic logic [31:0] round_const(input logic [5:0] r);
      logic [31:0] k;
      case (r)
         6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] pad_tail(input logic [31:0] w, input logic [1:0] n);
      logic [31:0] mask;
      case (n)
         2'd0:    mask = 32'h00000000;
         2'd1:    mask = 32'h000000ff;
         2'd2:    mask = 32'h0000ffff;
         default: mask = 32'h00ffffff;
      endcase
      return (w & mask) | (PAD_WORD << {n, 3'b000});
   endfunction

endpackage

[rtl/md5_if.sv]
// MD5 digest unit: request and response channel interfaces.
interface md5_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] message_word;
   logic [2:0]  byte_count;
   logic        last;

   modport source (output valid, message_word, byte_count, last, input ready);
   modport sink   (input valid, message_word, byte_count, last, output ready);
endinterface

interface md5_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_a;
   logic [31:0] digest_b;
   logic [31:0] digest_c;
   logic [31:0] digest_d;

   modport source (output valid, digest_a, digest_b, digest_c, digest_d, input ready);
   modport sink   (input valid, digest_a, digest_b, digest_c, digest_d, output ready);
endinterface

[rtl/md5_msg_mem.sv]
// MD5 digest unit: 16-word message block memory, one write and one registered read port.
module md5_msg_mem (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [3:0]  wr_addr,
   input  logic [31:0] wr_data,
   input  logic [3:0]  rd_addr,
   output logic [31:0] rd_data
);

   logic [31:0] mem_ff [md5_pkg::BLK_WORDS];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/md5_round_core.sv]
// MD5 digest unit: one-round-per-cycle compression engine and chaining words.
module md5_round_core (
   input  logic                  clock,
   input  logic                  reset,
   input  md5_pkg::core_ctrl_type ctrl,
   input  logic [31:0]           msg_word,
   output logic [3:0]            rd_addr,
   output md5_pkg::core_stat_type stat,
   output logic [31:0]           chain_a,
   output logic [31:0]           chain_b,
   output logic [31:0]           chain_c,
   output logic [31:0]           chain_d
);

   md5_pkg::core_state_type state_ff, state_in;
   logic [5:0]  round_ff, round_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, pre_ff;
   logic [31:0] a_in, b_in, c_in, d_in, pre_in;
   logic [31:0] ca_ff, cb_ff, cc_ff, cd_ff;
   logic [31:0] ca_in, cb_in, cc_in, cd_in;
   logic [31:0] f_val;
   logic [31:0] sum;
   logic [5:0]  round_nx;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= md5_pkg::CORE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ca_ff <= md5_pkg::IV_A;
         cb_ff <= md5_pkg::IV_B;
         cc_ff <= md5_pkg::IV_C;
         cd_ff <= md5_pkg::IV_D;
      end else begin
         ca_ff <= ca_in;
         cb_ff <= cb_in;
         cc_ff <= cc_in;
         cd_ff <= cd_in;
      end
   end

   always_ff @(posedge clock) begin
      round_ff <= round_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      d_ff     <= d_in;
      pre_ff   <= pre_in;
   end

   always_comb begin
      case (round_ff[5:4])
         2'd0:    f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1:    f_val = (b_ff & d_ff) | (c_ff & ~d_ff);
         2'd2:    f_val = b_ff ^ c_ff ^ d_ff;
         default: f_val = c_ff ^ (b_ff | ~d_ff);
      endcase
      // pre_ff already holds a + K for this round
      sum      = pre_ff + f_val + msg_word;
      round_nx = round_ff + 6'd1;
   end

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      pre_in   = pre_ff;
      ca_in    = ca_ff;
      cb_in    = cb_ff;
      cc_in    = cc_ff;
      cd_in    = cd_ff;
      rd_addr  = '0;
      stat     = '0;

      case (state_ff)
         md5_pkg::CORE_IDLE: begin
            if (ctrl.init) begin
               ca_in = md5_pkg::IV_A;
               cb_in = md5_pkg::IV_B;
               cc_in = md5_pkg::IV_C;
               cd_in = md5_pkg::IV_D;
            end
            if (ctrl.start) begin
               a_in     = ca_ff;
               b_in     = cb_ff;
               c_in     = cc_ff;
               d_in     = cd_ff;
               pre_in   = ca_ff + md5_pkg::round_const(6'd0);
               round_in = '0;
               state_in = md5_pkg::CORE_ROUND;
            end
         end
         md5_pkg::CORE_ROUND: begin
            stat.busy = 1'b1;
            rd_addr   = md5_pkg::msg_index(round_nx);
            a_in      = d_ff;
            d_in      = c_ff;
            c_in      = b_ff;
            b_in      = b_ff + md5_pkg::rotl32(sum, md5_pkg::rot_amount(round_ff));
            pre_in    = d_ff + md5_pkg::round_const(round_nx);
            round_in  = round_nx;
            if (round_ff == 6'd63) begin
               state_in = md5_pkg::CORE_ADD;
            end
         end
         md5_pkg::CORE_ADD: begin
            stat.busy = 1'b1;
            stat.done = 1'b1;
            ca_in     = ca_ff + a_ff;
            cb_in     = cb_ff + b_ff;
            cc_in     = cc_ff + c_ff;
            cd_in     = cd_ff + d_ff;
            state_in  = md5_pkg::CORE_IDLE;
         end
         default: begin
            state_in = md5_pkg::CORE_IDLE;
         end
      endcase
   end

   assign chain_a = ca_ff;
   assign chain_b = cb_ff;
   assign chain_c = cc_ff;
   assign chain_d = cd_ff;

endmodule

[rtl/md5_message_digest_unit.sv]
// MD5 digest unit: top level with request sequencing, padding and response register.
//
//   channel   dir   handshake      payload
//   req_if    in    valid/ready    message_word[31:0], byte_count[2:0], last
//   rsp_if    out   valid/ready    digest_a..digest_d[31:0]
//
// A request that does not fill the block is written and the unit stays ready; the 16th word of a block
// starts the compression: 64 rounds at one per cycle, then the chaining-word add.
// A last request pads the block one word per cycle, then compresses once or twice.
// Reset is synchronous and returns the chaining words to the MD5 initial values.
// A stalled response holds the next digest in the engine until the output frees.
module md5_message_digest_unit (
   input  logic     clock,
   input  logic     reset,
   md5_req_if.sink  req_if,
   md5_rsp_if.source rsp_if
);

   md5_pkg::ctrl_state_type state_ff, state_in;
   logic [3:0]  idx_ff, idx_in;
   logic [4:0]  pos_ff, pos_in;
   logic [63:0] bitlen_ff, bitlen_in;
   logic        pad_ff, pad_in;
   logic        fit_ff, fit_in;
   logic        fin_ff, fin_in;
   logic        rsp_valid_ff;
   logic [31:0] rsp_a_ff, rsp_b_ff, rsp_c_ff, rsp_d_ff;

   logic        req_fire;
   logic        rsp_load;
   logic [2:0]  nbytes;
   logic        mem_wr_en;
   logic [3:0]  mem_wr_addr;
   logic [31:0] mem_wr_data;
   logic [3:0]  mem_rd_addr;
   logic [31:0] mem_rd_data;
   logic [31:0] fill_word;

   md5_pkg::core_ctrl_type core_ctrl;
   md5_pkg::core_stat_type core_stat;
   logic [31:0] chain_a, chain_b, chain_c, chain_d;

   md5_msg_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   md5_round_core u_core (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (core_ctrl),
      .msg_word (mem_rd_data),
      .rd_addr  (mem_rd_addr),
      .stat     (core_stat),
      .chain_a  (chain_a),
      .chain_b  (chain_b),
      .chain_c  (chain_c),
      .chain_d  (chain_d)
   );

   assign req_fire = req_if.valid & req_if.ready;
   assign nbytes   = (req_if.byte_count > md5_pkg::FULL_BYTES) ? md5_pkg::FULL_BYTES
                                                               : req_if.byte_count;

   always_comb begin
      if (pad_ff) begin
         fill_word = md5_pkg::PAD_WORD;
      end else if (fit_ff && pos_ff == md5_pkg::LEN_LO_POS) begin
         fill_word = bitlen_ff[31:0];
      end else if (fit_ff && pos_ff == md5_pkg::LEN_HI_POS) begin
         fill_word = bitlen_ff[63:32];
      end else begin
         fill_word = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= md5_pkg::ST_IDLE;
         idx_ff    <= '0;
         pos_ff    <= '0;
         bitlen_ff <= '0;
         pad_ff    <= 1'b0;
         fit_ff    <= 1'b0;
         fin_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         pos_ff    <= pos_in;
         bitlen_ff <= bitlen_in;
         pad_ff    <= pad_in;
         fit_ff    <= fit_in;
         fin_ff    <= fin_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      bitlen_in    = bitlen_ff;
      pad_in       = pad_ff;
      fit_in       = fit_ff;
      fin_in       = fin_ff;
      req_if.ready = 1'b0;
      rsp_load     = 1'b0;
      core_ctrl    = '0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = idx_ff;
      mem_wr_data  = req_if.message_word;

      case (state_ff)
         md5_pkg::ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_fire) begin
               mem_wr_en = 1'b1;
               if (!req_if.last) begin
                  bitlen_in = bitlen_ff + md5_pkg::WORD_BITS;
                  idx_in    = idx_ff + 4'd1;
                  if (idx_ff == md5_pkg::LAST_WIDX) begin
                     core_ctrl.start = 1'b1;
                     fin_in          = 1'b0;
                     state_in        = md5_pkg::ST_COMPRESS;
                  end
               end else begin
                  // last word: a partial word is padded in place; a full one puts the pad byte into the following word
                  if (!nbytes[2]) begin
                     mem_wr_data = md5_pkg::pad_tail(req_if.message_word, nbytes[1:0]);
                  end
                  bitlen_in = bitlen_ff + 64'({nbytes, 3'b000});
                  pad_in    = nbytes[2];
                  fit_in    = !nbytes[2] && ({1'b0, idx_ff} <= md5_pkg::LEN_FIT_MAX);
                  pos_in    = {1'b0, idx_ff} + 5'd1;
                  fin_in    = 1'b1;
                  state_in  = md5_pkg::ST_FILL;
               end
            end
         end
         md5_pkg::ST_FILL: begin
            if (pos_ff[4]) begin
               core_ctrl.start = 1'b1;
               state_in        = md5_pkg::ST_COMPRESS;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = pos_ff[3:0];
               mem_wr_data = fill_word;
               pos_in      = pos_ff + 5'd1;
               if (pad_ff) begin
                  pad_in = 1'b0;
                  fit_in = (pos_ff <= md5_pkg::LEN_FIT_MAX);
               end
            end
         end
         md5_pkg::ST_COMPRESS: begin
            if (core_stat.done) begin
               if (!fin_ff) begin
                  state_in = md5_pkg::ST_IDLE;
               end else if (fit_ff) begin
                  state_in = md5_pkg::ST_OUTPUT;
               end else begin
                  // length did not fit: one more block
                  fit_in   = !pad_ff;
                  pos_in   = '0;
                  state_in = md5_pkg::ST_FILL;
               end
            end
         end
         md5_pkg::ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_load       = 1'b1;
               core_ctrl.init = 1'b1;
               idx_in         = '0;
               bitlen_in      = '0;
               fin_in         = 1'b0;
               state_in       = md5_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = md5_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_a_ff <= chain_a;
         rsp_b_ff <= chain_b;
         rsp_c_ff <= chain_c;
         rsp_d_ff <= chain_d;
      end
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.digest_a = rsp_a_ff;
   assign rsp_if.digest_b = rsp_b_ff;
   assign rsp_if.digest_c = rsp_c_ff;
   assign rsp_if.digest_d = rsp_d_ff;

   a_done_in_compress: assert property (@(posedge clock) disable iff (reset)
      core_stat.done |-> state_ff == md5_pkg::ST_COMPRESS)
      else $error("engine finished outside compress state");

   a_no_write_while_busy: assert property (@(posedge clock) disable iff (reset)
      core_stat.busy |-> !mem_wr_en)
      else $error("block memory written during compression");

   a_rsp_from_output: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == md5_pkg::ST_OUTPUT)
      else $error("response raised outside output state");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_if.ready |=> rsp_valid_ff)
      else $error("pending digest lost");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == md5_pkg::ST_FILL |-> pos_ff <= 5'd16)
      else $error("fill pointer out of range");

endmodule
